// ===== design/r2fft_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// r2fft_pkg
// Shared types, codes and twiddle generation for the radix-2 FFT core.
// ---------------------------------------------------------------------------
package r2fft_pkg;

	localparam int RES_W  = 26;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

	localparam longint Q30_ONE    = 64'sd1073741824;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN,
		ST_PAD,
		ST_REV_RA,
		ST_REV_RB,
		ST_REV_WA,
		ST_REV_WB,
		ST_BF_RA,
		ST_BF_RB,
		ST_BF_MUL,
		ST_BF_SUM,
		ST_BF_WA,
		ST_BF_WB,
		ST_DONE
	} fsm_state_t;

	function automatic logic signed [RES_W-1:0] sat_res(input logic signed [32:0] v);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		hi = 33'sd33554431;
		lo = -33'sd33554432;
		if (v > hi) begin
			return hi[RES_W-1:0];
		end else if (v < lo) begin
			return lo[RES_W-1:0];
		end
		return v[RES_W-1:0];
	endfunction

	function automatic longint to_q15(input longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		return (r > 64'sd32767) ? 64'sd32767 : r;
	endfunction

	// {sin, cos} of a * 2pi / 65536, first octant, Q1.15
	function automatic logic [31:0] octant_sincos(input longint a);
		longint x;
		longint x2;
		longint t;
		longint s;
		longint c;
		x  = (a * TWO_PI_Q30) >>> 16;
		x2 = (x * x) >>> 30;
		t  = Q30_ONE - x2 / 110;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 6;
		s  = to_q15((x * t) >>> 30);
		t  = Q30_ONE - x2 / 90;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
		t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
		c  = to_q15(t);
		return {s[15:0], c[15:0]};
	endfunction

	// {cos, sin} of a 16-bit phase
	function automatic logic [31:0] tw_sincos(input logic [15:0] ph);
		logic [1:0]         q;
		logic [13:0]        a;
		logic [31:0]        sc;
		logic signed [15:0] s0;
		logic signed [15:0] c0;
		logic signed [15:0] c;
		logic signed [15:0] s;
		q = ph[15:14];
		a = ph[13:0];
		if (a <= 14'd8192) begin
			sc = octant_sincos(longint'(a));
			s0 = sc[31:16];
			c0 = sc[15:0];
		end else begin
			sc = octant_sincos(longint'(15'd16384 - {1'b0, a}));
			c0 = sc[31:16];
			s0 = sc[15:0];
		end
		case (q)
			2'd0: begin c = c0;  s = s0;  end
			2'd1: begin c = -s0; s = c0;  end
			2'd2: begin c = -c0; s = -s0; end
			default: begin c = s0; s = -c0; end
		endcase
		return {c, s};
	endfunction

endpackage

// ===== design/radix2_fft_transform_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radix2_fft_transform_core
// In-place radix-2 DIT FFT / IFFT over a single-port-read sample memory.
// ---------------------------------------------------------------------------
// Usage
//   start/busy command port: a transaction is taken when start is high and
//   busy low. req_type 0 loads one sample, req_type 1 reads one bin.
//   Every transaction gives one result, shown for one cycle with done high;
//   the receiver cannot stall, so results are never held back.
//   Reads and ordinary loads: result in the cycle after acceptance, one
//   transaction per cycle while busy is low.
//   A load with last_sample pads, bit-reverses and transforms in place; busy
//   stays high throughout. It makes (len - count) zero pad writes, swaps each
//   index pair into bit-reversed order, runs log2(len) stages of len/2
//   butterflies, then gives the result. The butterfly sequencer (read a,
//   read b, multiply, round, write a, write b) shares the one memory read port.
//   inverse_mode is written via inverse_mode_we and latched per transform.
//   Reset clears counters and the length; sample memory is not cleared.
// ---------------------------------------------------------------------------
module radix2_fft_transform_core
	import r2fft_pkg::*;
#(
	parameter int MAX_POINTS   = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample_re,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample_im,
	input  logic                            last_sample,
	input  logic [$clog2(MAX_POINTS)-1:0]   read_index,
	input  logic                            inverse_mode_we,
	input  logic                            inverse_mode,
	output logic                            done,
	output logic signed [RES_W-1:0]         result_re,
	output logic signed [RES_W-1:0]         result_im,
	output logic [$clog2(MAX_POINTS):0]     length_used,
	output logic [STAT_W-1:0]               status
);

	localparam int LOG2N = $clog2(MAX_POINTS);
	localparam int DEPTH = 1 << LOG2N;
	localparam int CNT_W = LOG2N + 1;
	localparam int BIT_W = $clog2(LOG2N + 1);

	// sample memory and twiddle table
	logic [2*RES_W-1:0] mem [DEPTH];
	logic [2*RES_W-1:0] rdat_q;
	logic [LOG2N-1:0]   mem_ra;
	logic [LOG2N-1:0]   mem_wa;
	logic [2*RES_W-1:0] mem_wd;
	logic               mem_we;

	logic [31:0] tw_tab [DEPTH];
	for (genvar g = 0; g < DEPTH; g++) begin : g_tw
		assign tw_tab[g] = tw_sincos(16'(g * (65536 / DEPTH)));
	end

	fsm_state_t state_q, state_d;

	logic             inv_cfg_q, inv_q, vdone_q;
	logic [CNT_W-1:0] count_q, len_q, tlen_q, ptr_q;
	logic [BIT_W-1:0] bits_q, stage_q;
	logic [LOG2N-1:0] bf_q;
	logic             strobe_s1, isread_s1;
	logic [STAT_W-1:0] stat_s1, pend_stat_q;

	logic [2*RES_W-1:0] hold_q, a_q;
	logic [31:0]        tw_q;
	logic signed [41:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic signed [27:0] tr_q, ti_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// load bookkeeping
	logic [CNT_W-1:0] cnt_eff;
	logic             room;
	assign cnt_eff = vdone_q ? '0 : count_q;
	assign room    = (cnt_eff < CNT_W'(MAX_POINTS));

	// padded length search
	logic [CNT_W-1:0] len_c;
	logic [BIT_W-1:0] bits_c;
	always_comb begin
		len_c  = CNT_W'(1) << LOG2N;
		bits_c = BIT_W'(LOG2N);
		for (int b = LOG2N; b >= 0; b--) begin
			if ((CNT_W'(1) << b) >= count_q) begin
				len_c  = CNT_W'(1) << b;
				bits_c = BIT_W'(b);
			end
		end
	end

	// bit reversal of the reorder pointer
	logic [LOG2N-1:0] rev_full, rev_c;
	always_comb begin
		for (int b = 0; b < LOG2N; b++) begin
			rev_full[b] = ptr_q[LOG2N-1-b];
		end
	end
	assign rev_c = rev_full >> (BIT_W'(LOG2N) - bits_q);

	// butterfly addressing
	logic [LOG2N-1:0] half_mask, bf_j, addr_a, addr_b, tw_idx;
	assign half_mask = (LOG2N'(1) << (stage_q - BIT_W'(1))) - LOG2N'(1);
	assign bf_j      = bf_q & half_mask;
	assign addr_a    = ((bf_q & ~half_mask) << 1) | bf_j;
	assign addr_b    = addr_a | (half_mask + LOG2N'(1));
	assign tw_idx    = bf_j << (BIT_W'(LOG2N) - stage_q);

	// butterfly arithmetic
	logic signed [RES_W-1:0] br, bi, ar, ai;
	logic signed [15:0]      wr, wi;
	logic signed [42:0]      sum_re, sum_im;
	logic signed [28:0]      o0r, o0i, o1r, o1i;
	logic signed [28:0]      h0r, h0i, h1r, h1i;
	assign br = rdat_q[2*RES_W-1:RES_W];
	assign bi = rdat_q[RES_W-1:0];
	assign ar = a_q[2*RES_W-1:RES_W];
	assign ai = a_q[RES_W-1:0];
	assign wr = tw_q[31:16];
	assign wi = inv_q ? $signed(tw_q[15:0]) : -$signed(tw_q[15:0]);
	assign sum_re = 43'(p_rr_q) - 43'(p_ii_q) + 43'sd16384;
	assign sum_im = 43'(p_ri_q) + 43'(p_ir_q) + 43'sd16384;
	assign o0r = 29'(ar) + 29'(tr_q);
	assign o0i = 29'(ai) + 29'(ti_q);
	assign o1r = 29'(ar) - 29'(tr_q);
	assign o1i = 29'(ai) - 29'(ti_q);
	assign h0r = inv_q ? ((o0r + 29'sd1) >>> 1) : o0r;
	assign h0i = inv_q ? ((o0i + 29'sd1) >>> 1) : o0i;
	assign h1r = inv_q ? ((o1r + 29'sd1) >>> 1) : o1r;
	assign h1i = inv_q ? ((o1i + 29'sd1) >>> 1) : o1i;

	logic ptr_last, bf_last, stage_last;
	assign ptr_last   = (ptr_q == len_q - CNT_W'(1));
	assign bf_last    = ({1'b0, bf_q} == (len_q >> 1) - CNT_W'(1));
	assign stage_last = (stage_q == bits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = ptr_q[LOG2N-1:0];
		mem_wd  = '0;
		mem_ra  = ptr_q[LOG2N-1:0];
		case (state_q)
			ST_IDLE: begin
				mem_ra = read_index;
				mem_wa = cnt_eff[LOG2N-1:0];
				mem_wd = {sat_res(33'(sample_re)), sat_res(33'(sample_im))};
				if (accept && !req_type) begin
					mem_we = room;
					if (last_sample) begin
						state_d = ST_LEN;
					end
				end
			end
			ST_LEN: begin
				state_d = (count_q == len_c) ? ST_REV_RA : ST_PAD;
			end
			ST_PAD: begin
				mem_we = 1'b1;
				if (ptr_last) begin
					state_d = ST_REV_RA;
				end
			end
			ST_REV_RA: begin
				if ({1'b0, rev_c} > ptr_q) begin
					state_d = ST_REV_RB;
				end else if (ptr_last) begin
					state_d = (bits_q == '0) ? ST_DONE : ST_BF_RA;
				end
			end
			ST_REV_RB: begin
				mem_ra  = rev_c;
				state_d = ST_REV_WA;
			end
			ST_REV_WA: begin
				mem_we  = 1'b1;
				mem_wd  = rdat_q;
				state_d = ST_REV_WB;
			end
			ST_REV_WB: begin
				mem_we = 1'b1;
				mem_wa = rev_c;
				mem_wd = hold_q;
				if (ptr_last) begin
					state_d = (bits_q == '0) ? ST_DONE : ST_BF_RA;
				end else begin
					state_d = ST_REV_RA;
				end
			end
			ST_BF_RA: begin
				mem_ra  = addr_a;
				state_d = ST_BF_RB;
			end
			ST_BF_RB: begin
				mem_ra  = addr_b;
				state_d = ST_BF_MUL;
			end
			ST_BF_MUL: state_d = ST_BF_SUM;
			ST_BF_SUM: state_d = ST_BF_WA;
			ST_BF_WA: begin
				mem_we  = 1'b1;
				mem_wa  = addr_a;
				mem_wd  = {sat_res(33'(h0r)), sat_res(33'(h0i))};
				state_d = ST_BF_WB;
			end
			ST_BF_WB: begin
				mem_we  = 1'b1;
				mem_wa  = addr_b;
				mem_wd  = {sat_res(33'(h1r)), sat_res(33'(h1i))};
				state_d = (bf_last && stage_last) ? ST_DONE : ST_BF_RA;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdat_q <= mem[mem_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_cfg_q   <= 1'b0;
			inv_q       <= 1'b0;
			vdone_q     <= 1'b0;
			count_q     <= '0;
			len_q       <= '0;
			tlen_q      <= '0;
			ptr_q       <= '0;
			bits_q      <= '0;
			stage_q     <= '0;
			bf_q        <= '0;
			strobe_s1   <= 1'b0;
			isread_s1   <= 1'b0;
			stat_s1     <= STAT_OK;
			pend_stat_q <= STAT_OK;
		end else begin
			if (inverse_mode_we) begin
				inv_cfg_q <= inverse_mode;
			end
			// a last-sample load answers only once the transform is done
			strobe_s1 <= (state_q == ST_IDLE) ? (accept && (req_type || !last_sample))
				: (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						isread_s1 <= req_type;
						if (req_type) begin
							stat_s1   <= ({1'b0, read_index} < tlen_q) ? STAT_OK : STAT_RANGE;
						end else begin
							vdone_q <= 1'b0;
							count_q <= room ? cnt_eff + CNT_W'(1) : cnt_eff;
							if (last_sample) begin
								pend_stat_q <= room ? STAT_OK : STAT_DROPPED;
								inv_q       <= inv_cfg_q;
							end else begin
								stat_s1   <= room ? STAT_OK : STAT_DROPPED;
							end
						end
					end
				end
				ST_LEN: begin
					len_q  <= len_c;
					bits_q <= bits_c;
					ptr_q  <= (count_q == len_c) ? '0 : count_q;
				end
				ST_PAD: begin
					ptr_q <= ptr_last ? '0 : ptr_q + CNT_W'(1);
				end
				ST_REV_RA: begin
					if (!({1'b0, rev_c} > ptr_q)) begin
						ptr_q <= ptr_q + CNT_W'(1);
						if (ptr_last) begin
							stage_q <= BIT_W'(1);
							bf_q    <= '0;
						end
					end
				end
				ST_REV_WB: begin
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_last) begin
						stage_q <= BIT_W'(1);
						bf_q    <= '0;
					end
				end
				ST_BF_WB: begin
					if (bf_last) begin
						bf_q    <= '0;
						stage_q <= stage_q + BIT_W'(1);
					end else begin
						bf_q <= bf_q + LOG2N'(1);
					end
				end
				ST_DONE: begin
					tlen_q    <= len_q;
					vdone_q   <= 1'b1;
					isread_s1 <= 1'b0;
					stat_s1   <= pend_stat_q;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_REV_RB) begin
			hold_q <= rdat_q;
		end
		if (state_q == ST_BF_RA) begin
			tw_q <= tw_tab[tw_idx];
		end
		if (state_q == ST_BF_RB) begin
			a_q <= rdat_q;
		end
		if (state_q == ST_BF_MUL) begin
			p_rr_q <= br * wr;
			p_ii_q <= bi * wi;
			p_ri_q <= br * wi;
			p_ir_q <= bi * wr;
		end
		if (state_q == ST_BF_SUM) begin
			tr_q <= sum_re[42:15];
			ti_q <= sum_im[42:15];
		end
	end

	// result transaction
	logic show;
	assign show        = isread_s1 && (stat_s1 == STAT_OK);
	assign done        = strobe_s1;
	assign result_re   = show ? $signed(rdat_q[2*RES_W-1:RES_W]) : '0;
	assign result_im   = show ? $signed(rdat_q[RES_W-1:0]) : '0;
	assign length_used = tlen_q;
	assign status      = stat_s1;

endmodule
